### design/assert_macros.svh
// Assertion macros shared by the debounce design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLKD(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition never holds on any rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

### design/dbar_pkg.sv
// Package: types and constants of the two-key debounce and auto-repeat block.
package dbar_pkg;

   localparam int CFG_W             = 16;
   localparam int COUNT_WIDTH_DEF   = 16;
   localparam int CSR_ADDR_W        = 4;
   localparam int CSR_DATA_W        = 32;

   localparam logic [CFG_W-1:0] FIRST_DELAY_RST    = 16'd100;
   localparam logic [CFG_W-1:0] SLOW_INTERVAL_RST  = 16'd20;
   localparam logic [CFG_W-1:0] FAST_THRESHOLD_RST = 16'd300;
   localparam logic [CFG_W-1:0] FAST_INTERVAL_RST  = 16'd5;

   typedef enum logic [1:0] {
      REG_FIRST_DELAY    = 2'd0,
      REG_SLOW_INTERVAL  = 2'd1,
      REG_FAST_THRESHOLD = 2'd2,
      REG_FAST_INTERVAL  = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_SLOW = 2'd2,
      PH_FAST = 2'd3
   } phase_type;

   typedef struct packed {
      logic [CFG_W-1:0] first_delay;
      logic [CFG_W-1:0] slow_interval;
      logic [CFG_W-1:0] fast_threshold;
      logic [CFG_W-1:0] fast_interval;
   } cfg_type;

   typedef struct packed {
      logic advance;
      logic clear;
   } key_cmd_type;

endpackage

### design/dbar_key.sv
// Per-key press and two-speed auto-repeat state machine.
`include "assert_macros.svh"

module dbar_key
   import dbar_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  key_cmd_type cmd,
   input  cfg_type     cfg,
   output logic        fire
);

   localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

   phase_type              phase_ff,  phase_in;
   logic [COUNT_WIDTH-1:0] hold_ff,   hold_in;
   logic [COUNT_WIDTH-1:0] repeat_ff, repeat_in;
   logic [COUNT_WIDTH-1:0] hold_inc;
   logic [COUNT_WIDTH-1:0] repeat_inc;
   logic                   fire_raw;

   assign hold_inc   = hold_ff + COUNT_WIDTH'(1);
   assign repeat_inc = repeat_ff + COUNT_WIDTH'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         hold_ff   <= '0;
         repeat_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         hold_ff   <= hold_in;
         repeat_ff <= repeat_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      hold_in   = hold_ff;
      repeat_in = repeat_ff;
      fire_raw  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            fire_raw = 1'b1;
            phase_in = PH_WAIT;
         end
         PH_WAIT: begin
            hold_in = hold_inc;
            if (CMP_W'(hold_inc) >= CMP_W'(cfg.first_delay)) begin
               fire_raw = 1'b1;
               phase_in = PH_SLOW;
            end
         end
         PH_SLOW: begin
            hold_in   = hold_inc;
            repeat_in = repeat_inc;
            if (CMP_W'(repeat_inc) == CMP_W'(cfg.slow_interval)) begin
               fire_raw  = 1'b1;
               repeat_in = '0;
            end
            if (CMP_W'(hold_inc) >= CMP_W'(cfg.fast_threshold)) begin
               fire_raw = 1'b1;
               phase_in = PH_FAST;
            end
         end
         PH_FAST: begin
            hold_in = hold_inc;
            if (CMP_W'(hold_inc) >= CMP_W'(cfg.fast_interval)) begin
               fire_raw = 1'b1;
               hold_in  = '0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      if (cmd.clear) begin
         phase_in  = PH_IDLE;
         hold_in   = '0;
         repeat_in = '0;
      end else if (!cmd.advance) begin
         phase_in  = phase_ff;
         hold_in   = hold_ff;
         repeat_in = repeat_ff;
      end
   end

   assign fire = cmd.advance & fire_raw;

   `ASSERT_CLKD(a_clear_idles, cmd.clear |=> (phase_ff == PH_IDLE && hold_ff == '0 && repeat_ff == '0), "cleared key machine not idle")
   `ASSERT_CLKD(a_press_fires, (cmd.advance && phase_ff == PH_IDLE) |-> fire, "first press did not fire")
   `ASSERT_NEVER(a_cmd_excl, cmd.advance && cmd.clear, "key advanced and cleared together")

endmodule

### design/two_key_debounce_auto_repeat.sv
// Top level: two-key debounce with press event and two-speed auto-repeat.
// One input word is one tick carrying the raw active-low levels of keys A and B; each
// accepted word yields exactly one result word with the two event flags. A word is
// accepted every cycle while req_tready is high: the key state machines update at the
// accepting edge and the result is registered. A two-entry output buffer lets one
// further word be taken while rsp is stalled; req_tready drops only when both entries
// are full. Timing registers are to be written over the csr port while no tick is in
// flight (not enforced); hold and repeat counters are COUNT_WIDTH bits and wrap.
`include "assert_macros.svh"

module two_key_debounce_auto_repeat
   import dbar_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] raw_a, [1] raw_b, [7:2] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [0] event_a, [1] event_b, [7:2] zero
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type       cfg_ff;
   reg_index_type csr_index;
   logic          csr_write;

   logic          last_a_ff, last_b_ff;
   logic          accept;
   logic          press_a, press_b, release_any;
   key_cmd_type   cmd_a, cmd_b;
   logic          fire_a, fire_b;
   logic [1:0]    event_word;

   logic          out_valid_ff, skid_valid_ff;
   logic [1:0]    out_data_ff, skid_data_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_delay    <= FIRST_DELAY_RST;
         cfg_ff.slow_interval  <= SLOW_INTERVAL_RST;
         cfg_ff.fast_threshold <= FAST_THRESHOLD_RST;
         cfg_ff.fast_interval  <= FAST_INTERVAL_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_FIRST_DELAY:    cfg_ff.first_delay    <= csr_pwdata[CFG_W-1:0];
            REG_SLOW_INTERVAL:  cfg_ff.slow_interval  <= csr_pwdata[CFG_W-1:0];
            REG_FAST_THRESHOLD: cfg_ff.fast_threshold <= csr_pwdata[CFG_W-1:0];
            REG_FAST_INTERVAL:  cfg_ff.fast_interval  <= csr_pwdata[CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_FIRST_DELAY:    csr_prdata = CSR_DATA_W'(cfg_ff.first_delay);
         REG_SLOW_INTERVAL:  csr_prdata = CSR_DATA_W'(cfg_ff.slow_interval);
         REG_FAST_THRESHOLD: csr_prdata = CSR_DATA_W'(cfg_ff.fast_threshold);
         REG_FAST_INTERVAL:  csr_prdata = CSR_DATA_W'(cfg_ff.fast_interval);
         default:            csr_prdata = '0;
      endcase
   end

   // sample and arbitrate
   assign req_tready  = !skid_valid_ff;
   assign accept      = req_tvalid & req_tready;
   assign press_a     = (req_tdata[0] == last_a_ff) && !req_tdata[0];
   assign press_b     = (req_tdata[1] == last_b_ff) && !req_tdata[1];
   assign release_any = ((req_tdata[0] == last_a_ff) && req_tdata[0]) ||
                        ((req_tdata[1] == last_b_ff) && req_tdata[1]);

   always_comb begin
      cmd_a.advance = accept & press_a;
      cmd_b.advance = accept & !press_a & press_b;
      cmd_b.clear   = accept & (press_a | (!press_b & release_any));
      cmd_a.clear   = accept & !press_a & (press_b | release_any);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_a_ff <= 1'b1;
         last_b_ff <= 1'b1;
      end else if (accept) begin
         last_a_ff <= req_tdata[0];
         last_b_ff <= req_tdata[1];
      end
   end

   dbar_key #(.COUNT_WIDTH(COUNT_WIDTH)) u_key_a (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_a),
      .cfg   (cfg_ff),
      .fire  (fire_a)
   );

   dbar_key #(.COUNT_WIDTH(COUNT_WIDTH)) u_key_b (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_b),
      .cfg   (cfg_ff),
      .fire  (fire_b)
   );

   assign event_word = {fire_b, fire_a};

   // output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : event_word;
      end else if (accept) begin
         skid_data_ff <= event_word;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_data_ff};

   `ASSERT_CLKD(a_skid_behind_out, skid_valid_ff |-> out_valid_ff, "skid word without output word")
   `ASSERT_CLKD(a_stall_to_skid, (accept && out_valid_ff && !rsp_tready) |=> skid_valid_ff, "stalled word not held in skid")
   `ASSERT_NEVER(a_one_key_fires, fire_a && fire_b, "both keys fired on one tick")

endmodule
